// ===== hw/rtl/ffea_pkg.sv =====
// Shared types and constants for the first-fit extent allocator core.
// Holds the table entry layout, the sequencer states and the field widths.
// No dependencies.
package ffea_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int TBL_AW      = $clog2(MAX_ENTRIES);
    localparam int IDX_W       = 6;
    localparam int BLK_W       = 32;
    localparam int CFG_IDX_W   = 1;

    localparam int IN_DATA_W   = 104;
    localparam int OUT_DATA_W  = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START   = 1'd1;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // Status codes
    localparam logic STS_DONE    = 1'b0;
    localparam logic STS_NO_FIT  = 1'b1;

    typedef struct packed {
        logic             used;
        logic [BLK_W-1:0] start;
        logic [BLK_W-1:0] count;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_START,
        ST_OUTER_RD,
        ST_OUTER_WT,
        ST_CAND_SET,
        ST_SCAN,
        ST_CAND_DONE,
        ST_FINISH
    } t_state;

endpackage

// ===== hw/rtl/first_fit_extent_allocator_core.sv =====
// First-fit extent allocator: extent table in a one-port synchronous memory,
// scanned by a candidate/entry sequencer. Depends on ffea_pkg.
//
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tuser: cmd; tdata: entry fields, run length
// m_axis    out  m_axis_tvalid/tready        tuser: status; tdata: first block of the run
// cfg       in   i_cfg_valid/o_cfg_ready     i_cfg_index, i_cfg_data
//
// A write item passes through the idle, write and finish states. An allocate item
// tests up to MAX_ENTRIES+1 candidates; the candidate sweep reads the table one entry
// a cycle through its single read port, and candidates that cannot fit or cannot beat
// the best one found so far are skipped without a sweep.
// Reset clears all table entries at once through per-entry valid bits; no clearing pass.
// One item is in work at a time; a finished result waits in the output register while
// the next item is accepted.
module first_fit_extent_allocator_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [5:0] ext_slot, [6] entry_used, [38:7] entry_start, [70:39] entry_count,
    // [102:71] run_len, [103] zero
    input  logic [ffea_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] cmd
    input  logic                               s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] run_start
    output logic [ffea_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] status
    output logic                               m_axis_tuser,

    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ffea_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ffea_pkg::BLK_W-1:0]         i_cfg_data
);

    localparam int AW  = ffea_pkg::TBL_AW;
    localparam int BW  = ffea_pkg::BLK_W;
    localparam int CW  = AW + 1;
    localparam logic [CW-1:0] CNT_END = CW'(ffea_pkg::MAX_ENTRIES);

    // Table storage
    ffea_pkg::t_entry r_mem [ffea_pkg::MAX_ENTRIES];
    logic [ffea_pkg::MAX_ENTRIES-1:0] r_vld;
    ffea_pkg::t_entry r_rd_data;
    logic             r_rd_vld;
    ffea_pkg::t_entry w_rd_entry;

    // Control
    ffea_pkg::t_state r_state, n_state;
    logic             w_mem_we;
    logic [AW-1:0]    w_mem_addr;
    logic             w_out_load;

    // Captured item
    logic                       r_cmd;
    logic [ffea_pkg::IDX_W-1:0] r_idx;
    logic                       r_used;
    logic [BW-1:0]              r_estart;
    logic [BW-1:0]              r_ecount;
    logic [BW-1:0]              r_req;

    // Config
    logic [BW-1:0] r_total;
    logic [BW-1:0] r_dstart;

    // Search state
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [AW-1:0] r_oidx;
    logic [AW-1:0] r_pend_idx;
    logic          r_pend;
    logic [BW:0]   r_cand;
    logic [BW+1:0] r_cand_end;
    logic          r_elig;
    logic          r_cand_ok;
    logic          r_found;
    logic [BW:0]   r_best;

    // Output register
    logic          r_oval;
    logic          r_osts;
    logic [BW-1:0] r_oblk;

    logic          w_idx_in_range;
    logic [BW+1:0] w_cand_end;
    logic          w_precheck;
    logic          w_skip;
    logic [BW:0]   w_ent_end;
    logic          w_collide;
    logic          w_outer_done;

    assign w_rd_entry     = r_rd_vld ? r_rd_data : '0;
    assign w_idx_in_range = (32'(r_idx) < 32'(ffea_pkg::MAX_ENTRIES));
    assign w_cand_end     = {1'b0, r_cand} + {2'b00, r_req};
    assign w_precheck     = (r_cand >= {1'b0, r_dstart}) && (w_cand_end <= {2'b00, r_total});
    assign w_skip         = r_found && (r_cand >= r_best);
    assign w_ent_end      = {1'b0, w_rd_entry.start} + {1'b0, w_rd_entry.count};
    assign w_collide      = (32'(r_pend_idx) != 32'(r_idx)) && w_rd_entry.used
                          && (w_rd_entry.count != '0) && (r_cand < w_ent_end)
                          && ({2'b00, w_rd_entry.start} < r_cand_end);
    assign w_outer_done   = (r_i == CNT_END);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffea_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == ffea_pkg::CMD_WRITE) begin
                        n_state = ffea_pkg::ST_WRITE;
                    end else if (s_axis_tdata[102:71] == '0) begin
                        n_state = ffea_pkg::ST_FINISH;
                    end else begin
                        n_state = ffea_pkg::ST_START;
                    end
                end
            end
            ffea_pkg::ST_WRITE:    n_state = ffea_pkg::ST_FINISH;
            ffea_pkg::ST_START:    n_state = ffea_pkg::ST_CAND_SET;
            ffea_pkg::ST_OUTER_RD: n_state = ffea_pkg::ST_OUTER_WT;
            ffea_pkg::ST_OUTER_WT: n_state = ffea_pkg::ST_CAND_SET;
            ffea_pkg::ST_CAND_SET: begin
                if (r_elig && !w_skip && w_precheck) begin
                    n_state = ffea_pkg::ST_SCAN;
                end else if (w_outer_done) begin
                    n_state = ffea_pkg::ST_FINISH;
                end else begin
                    n_state = ffea_pkg::ST_OUTER_RD;
                end
            end
            ffea_pkg::ST_SCAN: begin
                if (r_j == CNT_END && !r_pend) begin
                    n_state = ffea_pkg::ST_CAND_DONE;
                end
            end
            ffea_pkg::ST_CAND_DONE: begin
                n_state = w_outer_done ? ffea_pkg::ST_FINISH : ffea_pkg::ST_OUTER_RD;
            end
            ffea_pkg::ST_FINISH: begin
                if (!r_oval || m_axis_tready) begin
                    n_state = ffea_pkg::ST_IDLE;
                end
            end
            default: n_state = ffea_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_mem_we      = 1'b0;
        w_mem_addr    = '0;
        w_out_load    = 1'b0;
        case (r_state)
            ffea_pkg::ST_IDLE:     s_axis_tready = 1'b1;
            ffea_pkg::ST_WRITE: begin
                w_mem_we   = w_idx_in_range;
                w_mem_addr = AW'(r_idx);
            end
            ffea_pkg::ST_OUTER_RD: w_mem_addr = r_i[AW-1:0];
            ffea_pkg::ST_SCAN:     w_mem_addr = r_j[AW-1:0];
            ffea_pkg::ST_FINISH:   w_out_load = !r_oval || m_axis_tready;
            default: begin
                w_mem_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffea_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Table memory: one write or one read a cycle, read data registered
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= '{used: r_used, start: r_estart, count: r_ecount};
        end
        r_rd_data <= r_mem[w_mem_addr];
    end

    // Valid bits stand in for the reset clear of the table; writes and reads never
    // overlap because one item is in work at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (w_mem_we) begin
                r_vld[w_mem_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[w_mem_addr];
        end
    end

    // Configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_dstart <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ffea_pkg::CFG_TOTAL_BLOCKS: r_total  <= i_cfg_data;
                ffea_pkg::CFG_DATA_START:   r_dstart <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Item capture and search datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            case (r_state)
                ffea_pkg::ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd    <= s_axis_tuser;
                        r_idx    <= s_axis_tdata[5:0];
                        r_used   <= s_axis_tdata[6];
                        r_estart <= s_axis_tdata[38:7];
                        r_ecount <= s_axis_tdata[70:39];
                        r_req    <= s_axis_tdata[102:71];
                        // writes and empty requests report success with block 0
                        r_found  <= (s_axis_tuser == ffea_pkg::CMD_WRITE)
                                 || (s_axis_tdata[102:71] == '0);
                        r_best   <= '0;
                    end
                end
                ffea_pkg::ST_START: begin
                    r_cand <= {1'b0, r_dstart};
                    r_elig <= 1'b1;
                    r_i    <= '0;
                end
                ffea_pkg::ST_OUTER_RD: begin
                    r_oidx <= r_i[AW-1:0];
                    r_i    <= r_i + CW'(1);
                end
                ffea_pkg::ST_OUTER_WT: begin
                    // candidate is the end of a used, non-empty, not ignored entry
                    r_cand <= w_ent_end;
                    r_elig <= (32'(r_oidx) != 32'(r_idx)) && w_rd_entry.used
                           && (w_rd_entry.count != '0);
                end
                ffea_pkg::ST_CAND_SET: begin
                    r_cand_end <= w_cand_end;
                    r_cand_ok  <= 1'b1;
                    r_j        <= '0;
                    r_pend     <= 1'b0;
                end
                ffea_pkg::ST_SCAN: begin
                    if (r_j != CNT_END) begin
                        r_j <= r_j + CW'(1);
                    end
                    r_pend     <= (r_j != CNT_END);
                    r_pend_idx <= r_j[AW-1:0];
                    if (r_pend && w_collide) begin
                        r_cand_ok <= 1'b0;
                    end
                end
                ffea_pkg::ST_CAND_DONE: begin
                    if (r_cand_ok) begin
                        r_found <= 1'b1;
                        r_best  <= r_cand;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (w_out_load) begin
            r_oval <= 1'b1;
            r_osts <= r_found ? ffea_pkg::STS_DONE : ffea_pkg::STS_NO_FIT;
            r_oblk <= r_found ? r_best[BW-1:0] : '0;
        end else if (m_axis_tready) begin
            r_oval <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tuser  = r_osts;
    assign m_axis_tdata  = r_oblk;

    // A failed allocation reports block 0.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ffea_pkg::STS_NO_FIT) |-> (m_axis_tdata == '0))
        else $error("failed allocation carries a nonzero block");

    // A found run starts at or above data_start and ends within the device.
    a_run_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffea_pkg::ST_FINISH && r_cmd == ffea_pkg::CMD_ALLOC && r_req != '0
         && r_found)
        |-> (r_best >= {1'b0, r_dstart}
             && ({1'b0, r_best} + {2'b00, r_req}) <= {2'b00, r_total}))
        else $error("allocated run lies outside the data area");

    // The outer candidate counter never runs past the table.
    a_outer_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffea_pkg::ST_OUTER_RD) |-> (r_i < CNT_END))
        else $error("outer entry read beyond the table");

endmodule
